### hdl/baro_temp_pressure_compensation_macros.svh
// Assertion macros for the barometric compensation checker.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BPTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BPTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/bptc_pkg.sv
// Shared types, constants and helpers for the barometric compensation pipeline.
`timescale 1ns / 1ps
package bptc_pkg;

    localparam int DIV_STEPS = 64;
    localparam int PIPE_LAT  = 23 + DIV_STEPS;

    localparam logic [1:0] CFG_TEMP_COEFFS = 2'd0;
    localparam logic [1:0] CFG_PRESS_LOW   = 2'd1;
    localparam logic [1:0] CFG_PRESS_HIGH  = 2'd2;
    localparam logic [1:0] CFG_PRESS_NINE  = 2'd3;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TEMP_RANGE  = 2'd1,
        ST_PRESS_RANGE = 2'd2,
        ST_ZERO_DIV    = 2'd3
    } t_status;

    localparam logic signed [63:0] TEMP_LIMIT_CENTI = 64'sd10000;
    localparam logic signed [63:0] PRESS_MIN_Q8     = 64'sd20480000;
    localparam logic signed [63:0] PRESS_MAX_Q8     = 64'sd30720000;
    localparam logic signed [63:0] PRESS_SAT_Q8     = 64'sd33554431;

    typedef struct packed {
        logic [15:0] tc;
        logic        temp_bad;
        logic        zero_div;
        logic        neg;
    } t_side;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] asr(input logic [63:0] x, input int unsigned n);
        return 64'($signed(x) >>> n);
    endfunction

endpackage

### hdl/bptc_mul64.sv
// Two-stage 64x64 multiplier giving the low 64 bits of the product.
`timescale 1ns / 1ps
module bptc_mul64 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_ll, n_ll;
    logic [31:0] r_lh, n_lh;
    logic [31:0] r_hl, n_hl;
    logic [63:0] r_p, n_p;
    logic [63:0] w_lh;
    logic [63:0] w_hl;

    // high x high only lands above bit 63: drop it
    always_comb begin
        n_ll = 64'(i_a[31:0]) * 64'(i_b[31:0]);
        w_lh = 64'(i_a[31:0]) * 64'(i_b[63:32]);
        w_hl = 64'(i_a[63:32]) * 64'(i_b[31:0]);
        n_lh = w_lh[31:0];
        n_hl = w_hl[31:0];
        n_p  = r_ll + {r_lh + r_hl, 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            r_p  <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

### hdl/bptc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side-band carried along.
`timescale 1ns / 1ps
module bptc_div (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [63:0]          i_num,
    input  logic [31:0]          i_den,
    input  bptc_pkg::t_side      i_side,
    output logic [63:0]          o_quot,
    output bptc_pkg::t_side      o_side
);
    logic [31:0]     r_rem [bptc_pkg::DIV_STEPS];
    logic [63:0]     r_q   [bptc_pkg::DIV_STEPS];
    logic [31:0]     r_den [bptc_pkg::DIV_STEPS];
    bptc_pkg::t_side r_sd  [bptc_pkg::DIV_STEPS];
    logic [31:0]     n_rem [bptc_pkg::DIV_STEPS];
    logic [63:0]     n_q   [bptc_pkg::DIV_STEPS];
    logic [31:0]     w_rem [bptc_pkg::DIV_STEPS];
    logic [63:0]     w_q   [bptc_pkg::DIV_STEPS];
    logic [31:0]     w_den [bptc_pkg::DIV_STEPS];
    bptc_pkg::t_side w_sd  [bptc_pkg::DIV_STEPS];

    always_comb begin
        w_rem[0] = 32'd0;
        w_q[0]   = i_num;
        w_den[0] = i_den;
        w_sd[0]  = i_side;
        for (int k = 1; k < bptc_pkg::DIV_STEPS; k++) begin
            w_rem[k] = r_rem[k-1];
            w_q[k]   = r_q[k-1];
            w_den[k] = r_den[k-1];
            w_sd[k]  = r_sd[k-1];
        end
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        logic [32:0] sh;
        logic [32:0] df;
        for (int k = 0; k < bptc_pkg::DIV_STEPS; k++) begin
            sh = {w_rem[k], w_q[k][63]};
            df = sh - {1'b0, w_den[k]};
            n_rem[k] = df[32] ? sh[31:0] : df[31:0];
            n_q[k]   = {w_q[k][62:0], ~df[32]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < bptc_pkg::DIV_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= w_den[k];
                r_sd[k]  <= w_sd[k];
            end
        end
    end

    assign o_quot = r_q[bptc_pkg::DIV_STEPS-1];
    assign o_side = r_sd[bptc_pkg::DIV_STEPS-1];
endmodule

### hdl/baro_temp_pressure_compensation.sv
// Barometric temperature and pressure compensation pipeline, 64-bit integer form.
// One raw temperature/pressure pair is taken per cycle while the output is not stalled;
// results leave in order; a full pipeline sustains one item per cycle unless stalled.
// Most of its depth is the 64-stage divider on magnitudes (one quotient bit per stage),
// plus two-stage 64-bit multipliers for the calibration products. A stall on the
// output side freezes the whole pipeline; nothing is dropped or repeated. The user must
// write calibration registers by the plain port only with no item in flight (unenforced).
`timescale 1ns / 1ps
module baro_temp_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // adc_temperature[19:0], adc_pressure[39:20]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // temperature_centideg[15:0], pressure_q17_8[40:16],
                                        // status[42:41], zero fill
);
    localparam int LAT = bptc_pkg::PIPE_LAT;

    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_low;
    logic [63:0] r_press_high;
    logic [15:0] r_press_nine;

    logic [LAT-1:0] r_vld;
    logic           w_en;

    logic [63:0] w_t1, w_t2, w_t3;
    logic [63:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_low   <= '0;
            r_press_high  <= '0;
            r_press_nine  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bptc_pkg::CFG_TEMP_COEFFS: r_temp_coeffs <= i_cfg_data[47:0];
                bptc_pkg::CFG_PRESS_LOW:   r_press_low   <= i_cfg_data;
                bptc_pkg::CFG_PRESS_HIGH:  r_press_high  <= i_cfg_data;
                bptc_pkg::CFG_PRESS_NINE:  r_press_nine  <= i_cfg_data[15:0];
                default:                   r_press_nine  <= r_press_nine;
            endcase
        end
    end

    assign w_t1 = 64'(r_temp_coeffs[15:0]);
    assign w_t2 = bptc_pkg::sx16(r_temp_coeffs[31:16]);
    assign w_t3 = bptc_pkg::sx16(r_temp_coeffs[47:32]);
    assign w_p1 = 64'(r_press_low[15:0]);
    assign w_p2 = bptc_pkg::sx16(r_press_low[31:16]);
    assign w_p3 = bptc_pkg::sx16(r_press_low[47:32]);
    assign w_p4 = bptc_pkg::sx16(r_press_low[63:48]);
    assign w_p5 = bptc_pkg::sx16(r_press_high[15:0]);
    assign w_p6 = bptc_pkg::sx16(r_press_high[31:16]);
    assign w_p7 = bptc_pkg::sx16(r_press_high[47:32]);
    assign w_p8 = bptc_pkg::sx16(r_press_high[63:48]);
    assign w_p9 = bptc_pkg::sx16(r_press_nine);

    // advance everything unless a finished item sits unclaimed at the output
    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // ---------------- temperature ----------------
    logic [19:0] r_adc_t1;
    logic [19:0] r_adcp [12];
    logic [63:0] w_x1, w_d, w_m1, w_m2, w_m3;
    logic [63:0] r_a4, r_a5, r_tf6, r_v1_7, r_tc7;
    logic [63:0] w_tf, w_tc_sum;
    logic [15:0] w_tc16;
    logic        w_temp_bad;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_adc_t1 <= s_axis_tdata[19:0];
            r_adcp[0] <= s_axis_tdata[39:20];
            for (int k = 1; k < 12; k++) begin
                r_adcp[k] <= r_adcp[k-1];
            end
        end
    end

    assign w_x1 = 64'(r_adc_t1 >> 3) - (w_t1 << 1);
    assign w_d  = 64'(r_adc_t1 >> 4) - w_t1;

    bptc_mul64 u_mul_a  (.i_clk(i_clk), .i_en(w_en), .i_a(w_x1), .i_b(w_t2), .o_p(w_m1));
    bptc_mul64 u_mul_dd (.i_clk(i_clk), .i_en(w_en), .i_a(w_d),  .i_b(w_d),  .o_p(w_m2));
    bptc_mul64 u_mul_b  (.i_clk(i_clk), .i_en(w_en), .i_a(bptc_pkg::asr(w_m2, 12)),
                         .i_b(w_t3), .o_p(w_m3));

    assign w_tf     = r_a5 + bptc_pkg::asr(w_m3, 14);
    assign w_tc_sum = (r_tf6 << 2) + r_tf6 + 64'd128;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a4   <= bptc_pkg::asr(w_m1, 11);
            r_a5   <= r_a4;
            r_tf6  <= w_tf;
            r_v1_7 <= r_tf6 - 64'd128000;
            r_tc7  <= bptc_pkg::asr(w_tc_sum, 8);
        end
    end

    always_comb begin
        w_temp_bad = ($signed(r_tc7) > bptc_pkg::TEMP_LIMIT_CENTI) ||
                     ($signed(r_tc7) < -bptc_pkg::TEMP_LIMIT_CENTI);
        priority if ($signed(r_tc7) > 64'sd32767) begin
            w_tc16 = 16'h7fff;
        end else if ($signed(r_tc7) < -64'sd32768) begin
            w_tc16 = 16'h8000;
        end else begin
            w_tc16 = r_tc7[15:0];
        end
    end

    // ---------------- pressure coefficients ----------------
    logic [63:0] w_m4, w_m5, w_m6, w_m7, w_m8, w_m9, w_m10;
    logic [63:0] r_m5_10, r_m5_11, r_m6_10, r_m6_11;
    logic [63:0] r_v2_12, r_v1b_12, w_v2, w_v1b, w_n0, w_den;
    logic [63:0] r_num15, r_den15, r_na16;
    logic [31:0] r_da16;
    logic [63:0] w_den_abs;
    bptc_pkg::t_side r_sd [8:16];

    bptc_mul64 u_mul_v1sq (.i_clk(i_clk), .i_en(w_en), .i_a(r_v1_7), .i_b(r_v1_7), .o_p(w_m4));
    bptc_mul64 u_mul_p5   (.i_clk(i_clk), .i_en(w_en), .i_a(r_v1_7), .i_b(w_p5),   .o_p(w_m5));
    bptc_mul64 u_mul_p2   (.i_clk(i_clk), .i_en(w_en), .i_a(r_v1_7), .i_b(w_p2),   .o_p(w_m6));
    bptc_mul64 u_mul_p6   (.i_clk(i_clk), .i_en(w_en), .i_a(w_m4),   .i_b(w_p6),   .o_p(w_m7));
    bptc_mul64 u_mul_p3   (.i_clk(i_clk), .i_en(w_en), .i_a(w_m4),   .i_b(w_p3),   .o_p(w_m8));

    assign w_v2  = w_m7 + (r_m5_11 << 17) + (w_p4 << 35);
    assign w_v1b = bptc_pkg::asr(w_m8, 8) + (r_m6_11 << 12);
    assign w_n0  = ((64'd1048576 - 64'(r_adcp[11])) << 31) - r_v2_12;

    bptc_mul64 u_mul_p1  (.i_clk(i_clk), .i_en(w_en), .i_a((64'd1 << 47) + r_v1b_12),
                          .i_b(w_p1), .o_p(w_m9));
    bptc_mul64 u_mul_num (.i_clk(i_clk), .i_en(w_en), .i_a(w_n0), .i_b(64'd3125),
                          .o_p(w_m10));

    assign w_den     = bptc_pkg::asr(w_m9, 33);
    assign w_den_abs = r_den15[63] ? (64'd0 - r_den15) : r_den15;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m5_10  <= w_m5;
            r_m5_11  <= r_m5_10;
            r_m6_10  <= w_m6;
            r_m6_11  <= r_m6_10;
            r_v2_12  <= w_v2;
            r_v1b_12 <= w_v1b;
            r_num15  <= w_m10;
            r_den15  <= w_den;
            r_na16   <= r_num15[63] ? (64'd0 - r_num15) : r_num15;
            r_da16   <= w_den_abs[31:0];
            r_sd[8]  <= '{tc: w_tc16, temp_bad: w_temp_bad, zero_div: 1'b0, neg: 1'b0};
            for (int k = 9; k < 15; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_sd[15] <= '{tc: r_sd[14].tc, temp_bad: r_sd[14].temp_bad,
                          zero_div: (w_den == 64'd0), neg: 1'b0};
            r_sd[16] <= '{tc: r_sd[15].tc, temp_bad: r_sd[15].temp_bad,
                          zero_div: r_sd[15].zero_div, neg: r_num15[63] ^ r_den15[63]};
        end
    end

    // ---------------- division and correction ----------------
    logic [63:0]     w_quot;
    bptc_pkg::t_side w_dsd;
    bptc_pkg::t_side r_sp [6];
    logic [63:0] r_p81, r_p82, r_p83, r_p84, r_p85, r_b84, r_b85, r_ps86;
    logic [63:0] w_s, w_m11, w_m12, w_m13, w_ps;

    bptc_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_na16),
        .i_den  (r_da16),
        .i_side (r_sd[16]),
        .o_quot (w_quot),
        .o_side (w_dsd)
    );

    assign w_s = bptc_pkg::asr(r_p81, 13);

    bptc_mul64 u_mul_ssq (.i_clk(i_clk), .i_en(w_en), .i_a(w_s),   .i_b(w_s),   .o_p(w_m11));
    bptc_mul64 u_mul_p8  (.i_clk(i_clk), .i_en(w_en), .i_a(w_p8),  .i_b(r_p81), .o_p(w_m12));
    bptc_mul64 u_mul_p9  (.i_clk(i_clk), .i_en(w_en), .i_a(w_p9),  .i_b(w_m11), .o_p(w_m13));

    assign w_ps = bptc_pkg::asr(r_p85 + bptc_pkg::asr(w_m13, 25) + r_b85, 8) + (w_p7 << 4);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p81  <= w_dsd.neg ? (64'd0 - w_quot) : w_quot;
            r_sp[0] <= w_dsd;
            for (int k = 1; k < 6; k++) begin
                r_sp[k] <= r_sp[k-1];
            end
            r_p82  <= r_p81;
            r_p83  <= r_p82;
            r_p84  <= r_p83;
            r_p85  <= r_p84;
            r_b84  <= bptc_pkg::asr(w_m12, 19);
            r_b85  <= r_b84;
            r_ps86 <= w_ps;
        end
    end

    // ---------------- result ----------------
    logic [15:0]       r_o_tc;
    logic [24:0]       r_o_press, w_press;
    bptc_pkg::t_status r_o_status, w_status;
    logic [24:0]       w_press_sat;
    logic              w_press_oor;

    always_comb begin
        w_press_oor = ($signed(r_ps86) < bptc_pkg::PRESS_MIN_Q8) ||
                      ($signed(r_ps86) > bptc_pkg::PRESS_MAX_Q8);
        priority if ($signed(r_ps86) < 64'sd0) begin
            w_press_sat = 25'd0;
        end else if ($signed(r_ps86) > bptc_pkg::PRESS_SAT_Q8) begin
            w_press_sat = '1;
        end else begin
            w_press_sat = r_ps86[24:0];
        end
    end

    always_comb begin
        priority if (r_sp[5].temp_bad) begin
            w_status = bptc_pkg::ST_TEMP_RANGE;
            w_press  = 25'd0;
        end else if (r_sp[5].zero_div) begin
            w_status = bptc_pkg::ST_ZERO_DIV;
            w_press  = 25'd0;
        end else begin
            w_status = w_press_oor ? bptc_pkg::ST_PRESS_RANGE : bptc_pkg::ST_OK;
            w_press  = w_press_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_tc     <= r_sp[5].tc;
            r_o_press  <= w_press;
            r_o_status <= w_status;
        end
    end

    assign m_axis_tdata = {5'd0, r_o_status, r_o_press, r_o_tc};
endmodule

### hdl/bptc_chk.sv
// Port-level checker for the barometric compensation block, bound to the top level.
`timescale 1ns / 1ps
`include "baro_temp_pressure_compensation_macros.svh"
module bptc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_addr,
    input logic [63:0] i_cfg_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    logic [15:0] w_tc;
    logic [24:0] w_press;
    logic [1:0]  w_status;
    logic        w_tc_hot;

    assign w_tc     = m_axis_tdata[15:0];
    assign w_press  = m_axis_tdata[40:16];
    assign w_status = m_axis_tdata[42:41];
    assign w_tc_hot = ($signed(w_tc) > 16'sd10000) || ($signed(w_tc) < -16'sd10000);

    `BPTC_ASSERT(a_hold_stalled, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `BPTC_ASSERT(a_temp_flag, i_clk, i_rst_n, m_axis_tvalid |-> ((w_status == bptc_pkg::ST_TEMP_RANGE) == w_tc_hot), "temperature flag disagrees with temperature")
    `BPTC_ASSERT(a_no_press, i_clk, i_rst_n, m_axis_tvalid && (w_status == bptc_pkg::ST_TEMP_RANGE || w_status == bptc_pkg::ST_ZERO_DIV) |-> w_press == 25'd0, "pressure given when not computed")
    `BPTC_ASSERT(a_ok_range, i_clk, i_rst_n, m_axis_tvalid && w_status == bptc_pkg::ST_OK |-> w_press >= 25'd20480000 && w_press <= 25'd30720000, "ok status with pressure out of range")
    `BPTC_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")
endmodule

bind baro_temp_pressure_compensation bptc_chk u_bptc_chk (.*);

### dv/baro_comp_checker.sv
// Checker for the barometric compensation block: predicts each result and compares it.
`timescale 1ns / 1ps
module baro_comp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,    // adc_temperature[19:0], adc_pressure[39:20]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,    // temperature_centideg[15:0], pressure_q17_8[40:16],
                                      // status[42:41], zero fill
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0]       temp_centi;
        logic [24:0]       press_q8;
        bptc_pkg::t_status status;
    } t_comp_result;

    logic [47:0] temp_cal;
    logic [63:0] press_cal_lo;
    logic [63:0] press_cal_hi;
    logic [15:0] press_cal_nine;

    t_comp_result expected_results[$];
    int           fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic logic [63:0] shr_arith(input logic [63:0] x, input int n);
        logic signed [63:0] sx;
        sx = x;
        return sx >>> n;
    endfunction

    function automatic logic [63:0] ext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic t_comp_result compensate(input logic [19:0] adc_t,
                                                input logic [19:0] adc_p);
        logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] xt, xp, a, b, d, t_fine, v1, v2, p, num, mag_n, mag_d, quot;
        logic signed [63:0] tc, ps;
        t_comp_result r;
        t1 = {48'd0, temp_cal[15:0]};
        t2 = ext16(temp_cal[31:16]);
        t3 = ext16(temp_cal[47:32]);
        p1 = {48'd0, press_cal_lo[15:0]};
        p2 = ext16(press_cal_lo[31:16]);
        p3 = ext16(press_cal_lo[47:32]);
        p4 = ext16(press_cal_lo[63:48]);
        p5 = ext16(press_cal_hi[15:0]);
        p6 = ext16(press_cal_hi[31:16]);
        p7 = ext16(press_cal_hi[47:32]);
        p8 = ext16(press_cal_hi[63:48]);
        p9 = ext16(press_cal_nine);
        xt = {44'd0, adc_t};
        xp = {44'd0, adc_p};
        r.press_q8 = '0;
        r.status   = bptc_pkg::ST_OK;

        a      = shr_arith(((xt >> 3) - (t1 << 1)) * t2, 11);
        d      = (xt >> 4) - t1;
        b      = shr_arith(shr_arith(d * d, 12) * t3, 14);
        t_fine = a + b;
        tc     = shr_arith(t_fine * 64'd5 + 64'd128, 8);

        if (tc > bptc_pkg::TEMP_LIMIT_CENTI || tc < -bptc_pkg::TEMP_LIMIT_CENTI) begin
            r.status = bptc_pkg::ST_TEMP_RANGE;
        end else begin
            v1 = t_fine - 64'd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) << 17);
            v2 = v2 + (p4 << 35);
            v1 = shr_arith(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
            v1 = shr_arith(((64'd1 << 47) + v1) * p1, 33);
            if (v1 == 64'd0) begin
                r.status = bptc_pkg::ST_ZERO_DIV;
            end else begin
                p     = 64'd1048576 - xp;
                num   = ((p << 31) - v2) * 64'd3125;
                // divide magnitudes, truncate toward zero
                mag_n = num[63] ? -num : num;
                mag_d = v1[63] ? -v1 : v1;
                quot  = mag_n / mag_d;
                p     = (num[63] ^ v1[63]) ? -quot : quot;
                a     = shr_arith(p9 * shr_arith(p, 13) * shr_arith(p, 13), 25);
                b     = shr_arith(p8 * p, 19);
                p     = shr_arith(p + a + b, 8) + (p7 << 4);
                ps    = p;
                if (ps < bptc_pkg::PRESS_MIN_Q8 || ps > bptc_pkg::PRESS_MAX_Q8)
                    r.status = bptc_pkg::ST_PRESS_RANGE;
                if (ps < 0)
                    r.press_q8 = '0;
                else if (ps > bptc_pkg::PRESS_SAT_Q8)
                    r.press_q8 = bptc_pkg::PRESS_SAT_Q8[24:0];
                else
                    r.press_q8 = ps[24:0];
            end
        end
        if (tc > 64'sd32767)
            tc = 64'sd32767;
        if (tc < -64'sd32768)
            tc = -64'sd32768;
        r.temp_centi = tc[15:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_comp_result exp_r;
        if (!i_rst_n) begin
            temp_cal       <= '0;
            press_cal_lo   <= '0;
            press_cal_hi   <= '0;
            press_cal_nine <= '0;
            fail_count     <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bptc_pkg::CFG_TEMP_COEFFS: temp_cal       <= i_cfg_data[47:0];
                    bptc_pkg::CFG_PRESS_LOW:   press_cal_lo   <= i_cfg_data;
                    bptc_pkg::CFG_PRESS_HIGH:  press_cal_hi   <= i_cfg_data;
                    bptc_pkg::CFG_PRESS_NINE:  press_cal_nine <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(compensate(i_s_tdata[19:0], i_s_tdata[39:20]));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %h at %0t", i_m_tdata, $realtime);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_m_tdata[15:0] !== exp_r.temp_centi
                            || i_m_tdata[40:16] !== exp_r.press_q8
                            || i_m_tdata[42:41] !== exp_r.status
                            || i_m_tdata[47:43] !== 5'd0) begin
                        if (fail_count < 10)
                            $display({"mismatch: temp exp %0d got %0d, press exp %0d got %0d,",
                                      " status exp %0d got %0d, fill %b"},
                                $signed(exp_r.temp_centi), $signed(i_m_tdata[15:0]),
                                exp_r.press_q8, i_m_tdata[40:16],
                                exp_r.status, i_m_tdata[42:41], i_m_tdata[47:43]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### dv/tb_top.sv
// Top of the barometric compensation testbench: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam int RUN_LIMIT = 500000;

    // sensor calibration from a typical datasheet example
    localparam logic [15:0] DS_T1 = 16'd27504, DS_T2 = 16'd26435, DS_T3 = -16'sd1000;
    localparam logic [15:0] DS_P1 = 16'd36477, DS_P2 = -16'sd10685, DS_P3 = 16'd3024;
    localparam logic [15:0] DS_P4 = 16'd2855, DS_P5 = 16'd140, DS_P6 = -16'sd7;
    localparam logic [15:0] DS_P7 = 16'd15500, DS_P8 = -16'sd14600, DS_P9 = 16'd6000;
    localparam int DS_ADC_T = 519888;
    localparam int DS_ADC_P = 415148;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = bptc_pkg::CFG_TEMP_COEFFS;
    logic [63:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // adc_temperature[19:0], adc_pressure[39:20]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // temperature_centideg[15:0], pressure_q17_8[40:16],
                                       // status[42:41], zero fill
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          items_sent = 0;
    bit          hold_request = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    baro_temp_pressure_compensation u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    baro_comp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall pattern, quiet stretches, and one long hold-off on request.
    initial begin
        int mode;
        int hold;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready = 1'b0;
                for (hold = 0; hold < 400; hold++)
                    @(negedge i_clk);
            end
            mode = (cycle_count / 256) % 4;
            if (mode == 0)
                m_axis_tready = 1'b1;
            else if (mode == 1)
                m_axis_tready = ($urandom_range(0, 9) != 0);
            else
                m_axis_tready = ($urandom_range(0, 2) == 0) ^ (mode == 3);
        end
    end

    task automatic write_reg(input logic [1:0] addr, input logic [63:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic load_cal(input logic [47:0] tc, input logic [63:0] plo,
                            input logic [63:0] phi, input logic [15:0] p9);
        write_reg(bptc_pkg::CFG_TEMP_COEFFS, {16'd0, tc});
        write_reg(bptc_pkg::CFG_PRESS_LOW, plo);
        write_reg(bptc_pkg::CFG_PRESS_HIGH, phi);
        write_reg(bptc_pkg::CFG_PRESS_NINE, {48'd0, p9});
    endtask

    // Offer one item in bursts; hold valid across back-to-back items.
    task automatic send_item(input logic [19:0] adc_t, input logic [19:0] adc_p);
        int gap;
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {adc_p, adc_t};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (bptc_pkg::PIPE_LAT + 8) @(negedge i_clk);
    endtask

    task automatic directed_items;
        send_item(20'd0, 20'd0);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'd0, 20'hFFFFF);
        send_item(20'hFFFFF, 20'd0);
        send_item(DS_ADC_T[19:0], DS_ADC_P[19:0]);
        send_item(20'h55555, 20'hAAAAA);
    endtask

    task automatic random_items(input int count);
        logic [19:0] t, p;
        repeat (count) begin
            if ($urandom_range(0, 4) == 0) begin
                t = 20'($urandom);
                p = 20'($urandom);
            end else begin
                t = 20'(DS_ADC_T + int'($urandom_range(0, 40000)) - 20000);
                p = 20'(DS_ADC_P + int'($urandom_range(0, 200000)) - 100000);
            end
            send_item(t, p);
        end
    endtask

    function automatic logic [15:0] jitter(input logic [15:0] v);
        return v + 16'($urandom_range(0, 64)) - 16'd32;
    endfunction

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset calibration: divisor is zero
        directed_items();
        random_items(20);
        drain();

        load_cal({DS_T3, DS_T2, DS_T1}, {DS_P4, DS_P3, DS_P2, DS_P1},
                 {DS_P8, DS_P7, DS_P6, DS_P5}, DS_P9);
        directed_items();
        send_item(20'd400000, 20'd200000);
        send_item(20'd600000, 20'd600000);
        random_items(200);
        hold_request = 1'b1;
        random_items(300);
        drain();

        // P1 zero forces a zero divisor with sane temperature
        load_cal({DS_T3, DS_T2, DS_T1}, {DS_P4, DS_P3, DS_P2, 16'd0},
                 {DS_P8, DS_P7, DS_P6, DS_P5}, 16'h8000);
        random_items(40);
        drain();

        load_cal('1, '1, '1, 16'h7FFF);
        directed_items();
        random_items(80);
        drain();

        load_cal(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
                 64'h8000_8000_8000_8000, 16'h8000);
        random_items(80);
        drain();

        load_cal(48'h7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0001,
                 64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
        random_items(80);
        drain();

        load_cal({jitter(DS_T3), jitter(DS_T2), jitter(DS_T1)},
                 {jitter(DS_P4), jitter(DS_P3), jitter(DS_P2), jitter(DS_P1)},
                 {jitter(DS_P8), jitter(DS_P7), jitter(DS_P6), jitter(DS_P5)},
                 jitter(DS_P9));
        random_items(200);
        drain();

        load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                 16'($urandom));
        random_items(80);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
